>>> rtl/pdfc_pkg.sv
// Package: widths, header offsets, result word type and CRC-32 byte update for the deframer.
package pdfc_pkg;

  // Header layout
  localparam int HEADER_BYTES = 20;
  localparam int COUNT_W      = 17;

  localparam logic [COUNT_W-1:0] OFS_ACK   = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] OFS_CSUM  = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] OFS_FLAGS = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] OFS_LEN   = COUNT_W'(16);
  localparam logic [COUNT_W-1:0] OFS_FRAG  = COUNT_W'(18);
  localparam logic [COUNT_W-1:0] HDR_LEN   = COUNT_W'(HEADER_BYTES);

  // Result FIFO depth (power of two, at least 2)
  localparam int RESULT_DEPTH = 4;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Result word kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_HDR_SHORT = 2'd1,
    ST_PAY_SHORT = 2'd2,
    ST_CRC_BAD   = 2'd3
  } pkt_status_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [31:0] stored_checksum;
    logic [7:0]  flag_bits;
    logic [15:0] payload_length;
    logic [15:0] fragment_length;
    pkt_status_t packet_status;
    logic        last_result;
  } result_t;

  // One byte through the CRC-32 register, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/pdfc_channels.sv
// Interfaces: input byte channel and result word channel, valid/ready handshake.
interface pdfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pdfc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [31:0] sequence_number;
  logic [31:0] ack_number;
  logic [31:0] stored_checksum;
  logic [7:0]  flag_bits;
  logic [15:0] payload_length;
  logic [15:0] fragment_length;
  logic [1:0]  packet_status;
  logic        last_result;

  modport source (output valid, output result_kind, output payload_byte,
                  output sequence_number, output ack_number, output stored_checksum,
                  output flag_bits, output payload_length, output fragment_length,
                  output packet_status, output last_result, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input sequence_number, input ack_number, input stored_checksum,
                  input flag_bits, input payload_length, input fragment_length,
                  input packet_status, input last_result, output ready);
endinterface

>>> rtl/pdfc_result_fifo.sv
// Result FIFO: takes up to two words per cycle, gives one per cycle on pop_ready, show-ahead.
module pdfc_result_fifo #(
  parameter int DEPTH = pdfc_pkg::RESULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_cnt,
  input  pdfc_pkg::result_t push0,
  input  pdfc_pkg::result_t push1,
  output logic              room2,
  output logic              pop_valid,
  input  logic              pop_ready,
  output pdfc_pkg::result_t pop_word
);
  import pdfc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  // Occupancy and pointers
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));
  assign pop_word  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage: first word at the write pointer, second just after it
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push1;
    end
  end

endmodule

>>> rtl/packet_deframer_crc_check_unit.sv
// Top level: byte-serial packet deframer with header parse and payload CRC-32 check.
//
// Usage
//   in_ch  : one packet byte per word (data_byte) with last_byte on the final byte.
//   out_ch : result words. result_kind 0 carries a payload byte; result_kind 1 is the
//            end-of-packet summary with header fields and packet_status.
//   cfg_wr_en / cfg_wr_data : big_endian_fields register, change only while idle.
// Timing
//   A byte is parsed in the cycle it is accepted; its words enter the result FIFO
//   behind any queued words. One byte is taken every cycle while the FIFO has room
//   for two words. A payload byte that is also the last byte yields two words.
//   The header fields, CRC and status are settled by one level of logic between the
//   input handshake and a four-word result FIFO; the CRC update is a byte-wide XOR net.
// Reset
//   Byte counter, header fields and FIFO clear, CRC loads all ones, the field order
//   register returns to most significant byte first.
// Back-pressure
//   in_ch.ready stays high while the result FIFO has room for two words; a stalled
//   receiver fills the FIFO past that point and so holds off the sender.
module packet_deframer_crc_check_unit #(
  parameter int RESULT_DEPTH = pdfc_pkg::RESULT_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  pdfc_in_if.sink    in_ch,
  pdfc_out_if.source out_ch,
  input  logic   cfg_wr_en,
  input  logic   cfg_wr_data
);
  import pdfc_pkg::*;

  // Packet state
  logic               big_endian_r;
  logic [COUNT_W-1:0] byte_cnt_r,   byte_cnt_nxt;
  logic [31:0]        seq_r,        seq_nxt;
  logic [31:0]        ack_r,        ack_nxt;
  logic [31:0]        csum_r,       csum_nxt;
  logic [7:0]         flags_r,      flags_nxt;
  logic [15:0]        len_r,        len_nxt;
  logic [15:0]        frag_r,       frag_nxt;
  logic [31:0]        crc_r,        crc_nxt;

  logic               in_acc;
  logic               in_hdr;
  logic               is_pay;
  logic [COUNT_W-1:0] pay_idx;
  logic               hdr_short;
  logic               pay_short;
  logic [31:0]        crc_upd;
  pkt_status_t        status;
  result_t            pay_res, sum_res, w0;
  logic [1:0]         push_cnt;
  logic               room2;
  result_t            pop_word;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room2;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b1;
    end else if (cfg_wr_en) begin
      big_endian_r <= cfg_wr_data;
    end
  end

  // Byte classification and field assembly
  always_comb begin
    in_hdr  = (byte_cnt_r < HDR_LEN);
    pay_idx = byte_cnt_r - HDR_LEN;
    is_pay  = !in_hdr && (pay_idx < {1'b0, len_r});
    crc_upd = crc32_byte(crc_r, in_ch.data_byte);

    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    csum_nxt  = csum_r;
    flags_nxt = flags_r;
    len_nxt   = len_r;
    frag_nxt  = frag_r;
    crc_nxt   = crc_r;

    if (in_hdr) begin
      if (byte_cnt_r < OFS_ACK) begin
        seq_nxt = big_endian_r ? {seq_r[23:0], in_ch.data_byte}
                               : {in_ch.data_byte, seq_r[31:8]};
      end else if (byte_cnt_r < OFS_CSUM) begin
        ack_nxt = big_endian_r ? {ack_r[23:0], in_ch.data_byte}
                               : {in_ch.data_byte, ack_r[31:8]};
      end else if (byte_cnt_r < OFS_FLAGS) begin
        csum_nxt = big_endian_r ? {csum_r[23:0], in_ch.data_byte}
                                : {in_ch.data_byte, csum_r[31:8]};
      end else if (byte_cnt_r == OFS_FLAGS) begin
        flags_nxt = in_ch.data_byte;
      end else if (byte_cnt_r >= OFS_LEN && byte_cnt_r < OFS_FRAG) begin
        len_nxt = big_endian_r ? {len_r[7:0], in_ch.data_byte}
                               : {in_ch.data_byte, len_r[15:8]};
      end else if (byte_cnt_r >= OFS_FRAG) begin
        frag_nxt = big_endian_r ? {frag_r[7:0], in_ch.data_byte}
                                : {in_ch.data_byte, frag_r[15:8]};
      end
    end else if (is_pay) begin
      crc_nxt = crc_upd;
    end

    // Saturating byte counter
    byte_cnt_nxt = (byte_cnt_r != '1) ? byte_cnt_r + COUNT_W'(1) : byte_cnt_r;
  end

  // Summary status
  always_comb begin
    hdr_short = (byte_cnt_nxt < HDR_LEN);
    pay_short = ({1'b0, byte_cnt_nxt} < ({1'b0, HDR_LEN} + {2'b00, len_nxt}));
    if (hdr_short) begin
      status = ST_HDR_SHORT;
    end else if (pay_short) begin
      status = ST_PAY_SHORT;
    end else if (csum_nxt == '0 || (crc_nxt ^ CRC_INIT) == csum_nxt) begin
      status = ST_OK;
    end else begin
      status = ST_CRC_BAD;
    end
  end

  // Result words for this byte
  always_comb begin
    pay_res              = '0;
    pay_res.result_kind  = KIND_PAYLOAD;
    pay_res.payload_byte = in_ch.data_byte;
    pay_res.last_result  = !in_ch.last_byte;

    sum_res               = '0;
    sum_res.result_kind   = KIND_SUMMARY;
    sum_res.packet_status = status;
    sum_res.last_result   = 1'b1;
    if (!hdr_short) begin
      sum_res.sequence_number = seq_nxt;
      sum_res.ack_number      = ack_nxt;
      sum_res.stored_checksum = csum_nxt;
      sum_res.flag_bits       = flags_nxt;
      sum_res.payload_length  = len_nxt;
      sum_res.fragment_length = frag_nxt;
    end

    w0       = is_pay ? pay_res : sum_res;
    push_cnt = in_acc ? (2'(is_pay) + 2'(in_ch.last_byte)) : 2'd0;
  end

  // State update; a last byte returns the packet state to reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      seq_r      <= '0;
      ack_r      <= '0;
      csum_r     <= '0;
      flags_r    <= '0;
      len_r      <= '0;
      frag_r     <= '0;
      crc_r      <= CRC_INIT;
    end else if (in_acc) begin
      if (in_ch.last_byte) begin
        byte_cnt_r <= '0;
        seq_r      <= '0;
        ack_r      <= '0;
        csum_r     <= '0;
        flags_r    <= '0;
        len_r      <= '0;
        frag_r     <= '0;
        crc_r      <= CRC_INIT;
      end else begin
        byte_cnt_r <= byte_cnt_nxt;
        seq_r      <= seq_nxt;
        ack_r      <= ack_nxt;
        csum_r     <= csum_nxt;
        flags_r    <= flags_nxt;
        len_r      <= len_nxt;
        frag_r     <= frag_nxt;
        crc_r      <= crc_nxt;
      end
    end
  end

  // Result FIFO
  pdfc_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (w0),
    .push1     (sum_res),
    .room2     (room2),
    .pop_valid (out_ch.valid),
    .pop_ready (out_ch.ready),
    .pop_word  (pop_word)
  );

  assign out_ch.result_kind     = pop_word.result_kind;
  assign out_ch.payload_byte    = pop_word.payload_byte;
  assign out_ch.sequence_number = pop_word.sequence_number;
  assign out_ch.ack_number      = pop_word.ack_number;
  assign out_ch.stored_checksum = pop_word.stored_checksum;
  assign out_ch.flag_bits       = pop_word.flag_bits;
  assign out_ch.payload_length  = pop_word.payload_length;
  assign out_ch.fragment_length = pop_word.fragment_length;
  assign out_ch.packet_status   = pop_word.packet_status;
  assign out_ch.last_result     = pop_word.last_result;

`ifndef SYNTHESIS
  // A last byte restarts the packet count
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_byte) |=> (byte_cnt_r == '0))
    else $error("byte count not cleared after last byte");

  // A byte that is not last always leaves a non-zero count
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_ch.last_byte) |=> (byte_cnt_r != '0))
    else $error("byte count zero after mid-packet byte");

  // Any byte that makes a word leaves a word valid on the output next cycle
  a_word_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (is_pay || in_ch.last_byte)) |=> out_ch.valid)
    else $error("result word missing after producing byte");
`endif

endmodule

>>> dv/tb_packet_deframer_crc_check_unit.sv
// Testbench for the packet deframer: directed and random framed byte streams checked against a local model.
`timescale 1ns / 100ps

module tb_packet_deframer_crc_check_unit;
  import pdfc_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1400;
  localparam int PHASE_BYTES  = 300;
  localparam longint LIMIT_CYCLES = 5_000_000;

  // Header field order as written to the register
  localparam bit ORDER_LSB_FIRST = 1'b0;
  localparam bit ORDER_MSB_FIRST = 1'b1;

  typedef enum int {CS_GOOD, CS_ZERO, CS_RANDOM} csum_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  logic clk         = 1'b0;
  logic rst_n       = 1'b0;
  logic cfg_wr_en   = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic drv_valid   = 1'b0;
  logic [7:0] drv_data = 8'h00;
  logic drv_last    = 1'b0;
  logic rcv_ready   = 1'b0;

  pdfc_in_if  in_ch ();
  pdfc_out_if out_ch ();

  assign in_ch.valid     = drv_valid;
  assign in_ch.data_byte = drv_data;
  assign in_ch.last_byte = drv_last;
  assign out_ch.ready    = rcv_ready;

  packet_deframer_crc_check_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Bytes waiting to be sent, and result words still owed by the block
  in_word_t   tx_bytes [$];
  result_t    due_words [$];
  logic [7:0] frame_buf [$];

  // Deframer model state
  bit          fields_msb_first = 1'b1;
  logic [16:0] byte_idx  = '0;
  logic [31:0] hdr_seq   = '0;
  logic [31:0] hdr_ack   = '0;
  logic [31:0] hdr_csum  = '0;
  logic [7:0]  hdr_flags = '0;
  logic [15:0] hdr_len   = '0;
  logic [15:0] hdr_frag  = '0;
  logic [31:0] pay_crc   = CRC_INIT;

  int fail_count    = 0;
  int bytes_seen    = 0;
  int packets_seen  = 0;
  int payload_seen  = 0;
  int cfg_writes    = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit byte_taken    = 1'b0;
  int gap_left      = 0;
  int burst_left    = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Field assembly, one byte at a time
  function automatic logic [31:0] shift32(input logic [31:0] f, input logic [7:0] b,
                                          input bit msb_first);
    return msb_first ? {f[23:0], b} : {b, f[31:8]};
  endfunction

  function automatic logic [15:0] shift16(input logic [15:0] f, input logic [7:0] b,
                                          input bit msb_first);
    return msb_first ? {f[7:0], b} : {b, f[15:8]};
  endfunction

  // Reflected CRC-32, data bits fed LSB first
  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r[0] ^ b[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Model: consume one accepted byte, queue the words it produces
  task automatic deframe_byte(input logic [7:0] b, input logic lst);
    result_t     w;
    logic [16:0] idx;
    logic [16:0] total;
    idx = byte_idx;
    if (idx < HDR_LEN) begin
      if (idx < OFS_ACK) hdr_seq = shift32(hdr_seq, b, fields_msb_first);
      else if (idx < OFS_CSUM) hdr_ack = shift32(hdr_ack, b, fields_msb_first);
      else if (idx < OFS_FLAGS) hdr_csum = shift32(hdr_csum, b, fields_msb_first);
      else if (idx == OFS_FLAGS) hdr_flags = b;
      else if (idx >= OFS_LEN && idx < OFS_FRAG)
        hdr_len = shift16(hdr_len, b, fields_msb_first);
      else if (idx >= OFS_FRAG) hdr_frag = shift16(hdr_frag, b, fields_msb_first);
    end else if (idx - HDR_LEN < {1'b0, hdr_len}) begin
      pay_crc = crc_step(pay_crc, b);
      w = '0;
      w.result_kind  = KIND_PAYLOAD;
      w.payload_byte = b;
      w.last_result  = !lst;
      due_words.push_back(w);
    end
    // counter saturates at all ones
    total = (idx == '1) ? idx : idx + 17'd1;
    byte_idx = total;
    if (lst) begin
      w = '0;
      w.result_kind = KIND_SUMMARY;
      w.last_result = 1'b1;
      if (total < HDR_LEN) begin
        w.packet_status = ST_HDR_SHORT;
      end else begin
        w.sequence_number = hdr_seq;
        w.ack_number      = hdr_ack;
        w.stored_checksum = hdr_csum;
        w.flag_bits       = hdr_flags;
        w.payload_length  = hdr_len;
        w.fragment_length = hdr_frag;
        if (int'(total) < HEADER_BYTES + int'(hdr_len)) w.packet_status = ST_PAY_SHORT;
        else if (hdr_csum == '0 || ~pay_crc == hdr_csum) w.packet_status = ST_OK;
        else w.packet_status = ST_CRC_BAD;
      end
      due_words.push_back(w);
      byte_idx  = '0;
      hdr_seq   = '0;
      hdr_ack   = '0;
      hdr_csum  = '0;
      hdr_flags = '0;
      hdr_len   = '0;
      hdr_frag  = '0;
      pay_crc   = CRC_INIT;
    end
  endtask

  function automatic string show_word(input result_t w);
    return $sformatf({"kind=%0d byte=%02h seq=%08h ack=%08h csum=%08h flags=%02h",
                      " len=%0d frag=%0d st=%0d last=%0d"},
                     w.result_kind, w.payload_byte, w.sequence_number, w.ack_number,
                     w.stored_checksum, w.flag_bits, w.payload_length, w.fragment_length,
                     w.packet_status, w.last_result);
  endfunction

  function automatic string word_diffs(input result_t want, input result_t got);
    string d;
    d = "";
    if (got.result_kind !== want.result_kind) d = {d, " result_kind"};
    if (got.payload_byte !== want.payload_byte) d = {d, " payload_byte"};
    if (got.sequence_number !== want.sequence_number) d = {d, " sequence_number"};
    if (got.ack_number !== want.ack_number) d = {d, " ack_number"};
    if (got.stored_checksum !== want.stored_checksum) d = {d, " stored_checksum"};
    if (got.flag_bits !== want.flag_bits) d = {d, " flag_bits"};
    if (got.payload_length !== want.payload_length) d = {d, " payload_length"};
    if (got.fragment_length !== want.fragment_length) d = {d, " fragment_length"};
    if (got.packet_status !== want.packet_status) d = {d, " packet_status"};
    if (got.last_result !== want.last_result) d = {d, " last_result"};
    return d;
  endfunction

  task automatic flag_fail(input string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Monitor: result words, accepted bytes and register writes, all at the rising edge
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    string   diffs;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind     = out_ch.result_kind;
        got.payload_byte    = out_ch.payload_byte;
        got.sequence_number = out_ch.sequence_number;
        got.ack_number      = out_ch.ack_number;
        got.stored_checksum = out_ch.stored_checksum;
        got.flag_bits       = out_ch.flag_bits;
        got.payload_length  = out_ch.payload_length;
        got.fragment_length = out_ch.fragment_length;
        got.packet_status   = pkt_status_t'(out_ch.packet_status);
        got.last_result     = out_ch.last_result;
        if (due_words.size() == 0) begin
          flag_fail({"word with nothing expected: ", show_word(got)});
        end else begin
          want  = due_words.pop_front();
          diffs = word_diffs(want, got);
          if (diffs != "") begin
            flag_fail({"mismatch in", diffs, "\n  expected ", show_word(want),
                       "\n  actual   ", show_word(got)});
          end else if (got.result_kind == KIND_SUMMARY) begin
            status_seen[got.packet_status]++;
          end else begin
            payload_seen++;
          end
        end
      end
      byte_taken = in_ch.valid && in_ch.ready;
      if (byte_taken) begin
        void'(tx_bytes.pop_front());
        deframe_byte(in_ch.data_byte, in_ch.last_byte);
        bytes_seen++;
        if (in_ch.last_byte) packets_seen++;
      end
      // a write takes effect for bytes after this edge
      if (cfg_wr_en) fields_msb_first = cfg_wr_data;
    end else begin
      byte_taken = 1'b0;
    end
  end

  // Driver: bursts of words with random gaps, held until taken
  always @(negedge clk) begin : byte_driver
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (drv_valid && !byte_taken) begin
      // hold the offered word
    end else if (gap_left > 0) begin
      gap_left--;
      drv_valid <= 1'b0;
      drv_data  <= 8'($urandom);
    end else if (tx_bytes.size() > 0) begin
      drv_valid <= 1'b1;
      drv_data  <= tx_bytes[0].data;
      drv_last  <= tx_bytes[0].last;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                 : $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // Receiver stall pattern: rotating mask, reloaded when the 6-bit age counter wraps
  always @(negedge clk) begin : stall_pattern
    logic [31:0] mask;
    logic [5:0]  age;
    if (!rst_n) begin
      rcv_ready <= 1'b0;
      mask = '1;
      age  = '0;
    end else begin
      if (age == 0) begin
        case ($urandom_range(0, 3))
          0:       mask = '1;
          1:       mask = $urandom | 32'h1;
          default: mask = $urandom | $urandom | 32'h1;
        endcase
      end
      rcv_ready <= mask[0];
      mask = {mask[0], mask[31:1]};
      age  = age + 6'd1;
    end
  end

  // Frame building
  task automatic put_field(input logic [31:0] v, input int nbytes, input bit msb_first);
    for (int i = 0; i < nbytes; i++) begin
      frame_buf.push_back(msb_first ? v[8*(nbytes-1-i) +: 8] : v[8*i +: 8]);
    end
  endtask

  // Header in the given order, pay_n payload bytes, pad_n trailing bytes;
  // cut_at > 0 truncates the frame to that many bytes
  task automatic build_frame(input logic [31:0] seq, input logic [31:0] ack,
                             input csum_mode_t cs, input logic [7:0] flags,
                             input logic [15:0] len_field, input logic [15:0] frag,
                             input int pay_n, input int pad_n, input int cut_at,
                             input bit msb_first);
    logic [7:0]  pay [$];
    logic [31:0] crc;
    logic [31:0] csum;
    crc = CRC_INIT;
    for (int i = 0; i < pay_n; i++) begin
      pay.push_back(8'($urandom));
      crc = crc_step(crc, pay[i]);
    end
    case (cs)
      CS_GOOD: csum = ~crc;
      CS_ZERO: csum = '0;
      default: csum = $urandom | 32'h1;
    endcase
    frame_buf.delete();
    put_field(seq, 4, msb_first);
    put_field(ack, 4, msb_first);
    put_field(csum, 4, msb_first);
    frame_buf.push_back(flags);
    repeat (3) frame_buf.push_back(8'($urandom));
    put_field({16'h0, len_field}, 2, msb_first);
    put_field({16'h0, frag}, 2, msb_first);
    foreach (pay[i]) frame_buf.push_back(pay[i]);
    repeat (pad_n) frame_buf.push_back(8'($urandom));
    if (cut_at > 0) begin
      while (frame_buf.size() > cut_at) void'(frame_buf.pop_back());
    end
  endtask

  // Queue frame_buf[lo..hi-1]; the frame's final byte carries the last mark
  task automatic send_range(input int lo, input int hi);
    in_word_t w;
    for (int i = lo; i < hi; i++) begin
      w.data = frame_buf[i];
      w.last = (i == frame_buf.size() - 1);
      tx_bytes.push_back(w);
    end
  endtask

  task automatic send_frame();
    send_range(0, frame_buf.size());
  endtask

  // One random packet, mostly well formed
  task automatic random_packet(input bit order);
    int         pick;
    int         pay_n;
    int         pad_n;
    int         cut_at;
    logic [15:0] len;
    csum_mode_t cs;
    pick   = $urandom_range(0, 99);
    len    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(41, 160))
                                         : 16'($urandom_range(0, 40));
    pay_n  = int'(len);
    pad_n  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    cut_at = 0;
    case ($urandom_range(0, 9))
      0, 1:    cs = CS_ZERO;
      2, 3, 4: cs = CS_RANDOM;
      default: cs = CS_GOOD;
    endcase
    if (pick >= 70 && pick < 78) begin
      cut_at = $urandom_range(1, HEADER_BYTES - 1);
    end else if (pick >= 78 && pick < 86) begin
      // payload short, length over the full field range
      len   = 16'($urandom);
      pay_n = $urandom_range(0, 30);
      if (pay_n > int'(len)) pay_n = int'(len);
      pad_n = 0;
    end else if (pick >= 86 && pick < 93) begin
      order = !order;
    end
    if (pick >= 93) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 60)) frame_buf.push_back(8'($urandom));
    end else begin
      build_frame($urandom, $urandom, cs, 8'($urandom), len, 16'($urandom),
                  pay_n, pad_n, cut_at, order);
    end
    send_frame();
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() != 0 || due_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_field_order(input bit order);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_writes++;
  endtask

  // Stimulus: directed packets, then random phases
  initial begin : stimulus
    int sent_random;
    int phase_bytes;
    int ph;
    bit order;
    sent_random = 0;
    ph = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset order: most significant byte first
    build_frame(32'h0102_0304, 32'hA0B0_C0D0, CS_GOOD, 8'h81, 16'd4, 16'd4, 4, 0, 0,
                ORDER_MSB_FIRST);
    send_frame();
    build_frame(32'hFFFF_FFFF, 32'h0000_0000, CS_ZERO, 8'hFF, 16'd3, 16'hFFFF, 3, 0, 0,
                ORDER_MSB_FIRST);
    send_frame();
    build_frame(32'h0000_0000, 32'hFFFF_FFFF, CS_RANDOM, 8'h00, 16'd5, 16'h0000, 5, 0, 0,
                ORDER_MSB_FIRST);
    send_frame();
    // header short: a single byte, then 19 bytes
    build_frame($urandom, $urandom, CS_GOOD, 8'h55, 16'd2, 16'd0, 2, 0, 1, ORDER_MSB_FIRST);
    send_frame();
    build_frame($urandom, $urandom, CS_GOOD, 8'hAA, 16'd2, 16'd0, 2, 0, 19, ORDER_MSB_FIRST);
    send_frame();
    // header only, empty payload
    build_frame($urandom, $urandom, CS_GOOD, 8'h01, 16'd0, 16'd7, 0, 0, 0, ORDER_MSB_FIRST);
    send_frame();
    // payload short against the largest length
    build_frame($urandom, $urandom, CS_GOOD, 8'h80, 16'hFFFF, 16'd9, 3, 0, 0,
                ORDER_MSB_FIRST);
    send_frame();
    // trailing bytes past the payload are dropped, last mark on a dropped byte
    build_frame($urandom, $urandom, CS_GOOD, 8'h3C, 16'd2, 16'd2, 2, 4, 0, ORDER_MSB_FIRST);
    send_frame();
    wait_drained();

    // least significant byte first; the second frame is built most significant first
    set_field_order(ORDER_LSB_FIRST);
    build_frame(32'h0102_0304, 32'h1122_3344, CS_GOOD, 8'hC3, 16'd6, 16'h0102, 6, 0, 0,
                ORDER_LSB_FIRST);
    send_frame();
    build_frame($urandom, $urandom, CS_GOOD, 8'h18, 16'd3, 16'd3, 3, 0, 0, ORDER_MSB_FIRST);
    send_frame();
    build_frame($urandom, $urandom, CS_ZERO, 8'h42, 16'd0, 16'd0, 0, 2, 0, ORDER_LSB_FIRST);
    send_frame();
    wait_drained();

    // order changed part way through a header
    build_frame(32'hDEAD_BEEF, 32'h0BAD_F00D, CS_RANDOM, 8'h24, 16'd2, 16'd5, 2, 0, 0,
                ORDER_LSB_FIRST);
    send_range(0, 10);
    wait_drained();
    set_field_order(ORDER_MSB_FIRST);
    send_range(10, frame_buf.size());
    wait_drained();

    // random phases, each under a field order of its own
    while (sent_random < RANDOM_BYTES) begin
      order = (ph == 0) ? ORDER_LSB_FIRST :
              (ph == 1) ? ORDER_MSB_FIRST : bit'($urandom_range(0, 1));
      set_field_order(order);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        random_packet(order);
        phase_bytes += frame_buf.size();
      end
      sent_random += phase_bytes;
      wait_drained();
      ph++;
    end

    $display("Covered %0d bytes in %0d packets, %0d payload words, %0d register writes.",
             bytes_seen, packets_seen, payload_seen, cfg_writes);
    $display("Summaries: ok %0d, header short %0d, payload short %0d, checksum bad %0d.",
             status_seen[ST_OK], status_seen[ST_HDR_SHORT], status_seen[ST_PAY_SHORT],
             status_seen[ST_CRC_BAD]);
    if (fail_count == 0 && due_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d words outstanding.", due_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
